FILE: rtl/mssp_pkg.sv
// ----------------------------------------------------------------------------
// mssp_pkg: shared definitions for the multi-stack shared pool
// Default sizes, command and status codes and the control state type.
// ----------------------------------------------------------------------------
package mssp_pkg;

    localparam int DEF_POOL_SLOTS  = 64;
    localparam int DEF_STACK_COUNT = 4;

    localparam int CMD_W    = 1;
    localparam int SEL_IN_W = 2;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;

    typedef logic [CMD_W-1:0]    cmd_t;
    typedef logic [SEL_IN_W-1:0] sel_t;
    typedef logic [DATA_W-1:0]   data_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam cmd_t CMD_PUSH = 1'b0;
    localparam cmd_t CMD_POP  = 1'b1;

    localparam status_t STATUS_DONE  = 2'd0;
    localparam status_t STATUS_FULL  = 2'd1;
    localparam status_t STATUS_EMPTY = 2'd2;

    typedef enum logic
    {
        ST_IDLE,
        ST_EXEC
    } state_t;

endpackage

FILE: rtl/mssp_cmd_if.sv
// ----------------------------------------------------------------------------
// mssp_cmd_if: command channel of the multi-stack shared pool
// Carries one push or pop request per transfer.
// ----------------------------------------------------------------------------
interface mssp_cmd_if;
    import mssp_pkg::*;

    logic          valid;
    logic          ready;
    cmd_t          command;
    sel_t          stack_sel;
    logic signed [DATA_W-1:0] push_value;

    modport source (output valid, output command, output stack_sel, output push_value,
                    input ready);
    modport sink   (input valid, input command, input stack_sel, input push_value,
                    output ready);
endinterface

FILE: rtl/mssp_rsp_if.sv
// ----------------------------------------------------------------------------
// mssp_rsp_if: response channel of the multi-stack shared pool
// Carries one status and popped value per transfer.
// ----------------------------------------------------------------------------
interface mssp_rsp_if;
    import mssp_pkg::*;

    logic          valid;
    logic          ready;
    status_t       status;
    logic signed [DATA_W-1:0] pop_value;

    modport source (output valid, output status, output pop_value, input ready);
    modport sink   (input valid, input status, input pop_value, output ready);
endinterface

FILE: rtl/multi_stack_shared_pool.sv
// ----------------------------------------------------------------------------
// multi_stack_shared_pool: several LIFO stacks sharing one slot pool
// Each request on the cmd channel pushes a word onto, or pops a word from,
// one of STACK_COUNT stacks. Free slots are kept on a linked free list.
// Every request gives exactly one response on the rsp channel: status
// (done, pool full on push, stack empty on pop) and the popped word, which
// is zero for pushes and refused pops.
// A request runs through ST_IDLE and ST_EXEC: the slot's link and data are
// read from synchronous RAM as the request is accepted in ST_IDLE, and the
// links, tops and free head are written back in ST_EXEC. One request is in
// flight at a time, so no new request is accepted until the previous one
// leaves ST_EXEC, which is also when its response enters the rsp register.
// The rsp register lets a request be accepted while the previous response
// still waits; if the receiver stalls, the block holds in ST_EXEC until the
// register is free and accepts nothing new.
// After reset every stack is empty and all slots are free in index order.
// No clearing pass is needed: a fill mark tracks which slots have never
// been linked, and those read as chained to the next index.
// ----------------------------------------------------------------------------
module multi_stack_shared_pool #(
    parameter int POOL_SLOTS  = mssp_pkg::DEF_POOL_SLOTS,
    parameter int STACK_COUNT = mssp_pkg::DEF_STACK_COUNT
) (
    input  logic clk,
    input  logic rst_n,
    mssp_cmd_if.sink   cmd,
    mssp_rsp_if.source rsp
);
    import mssp_pkg::*;

    localparam int PTR_W  = $clog2(POOL_SLOTS + 1);
    localparam int ADDR_W = $clog2(POOL_SLOTS);
    localparam int SEL_W  = (STACK_COUNT > 1) ? $clog2(STACK_COUNT) : 1;
    localparam logic [PTR_W-1:0] PTR_NULL = PTR_W'(POOL_SLOTS);

    state_t state_reg, state_next;

    logic [PTR_W-1:0] stack_top_reg [STACK_COUNT];
    logic [PTR_W-1:0] free_head_reg, free_head_next;
    logic [PTR_W-1:0] fill_reg, fill_next;

    cmd_t             op_cmd_reg;
    logic [SEL_W-1:0] op_idx_reg;
    data_t            op_val_reg;
    logic [PTR_W-1:0] op_slot_reg;
    logic             op_ok_reg;
    logic             op_fresh_reg;
    status_t          op_status_reg;

    logic    rsp_valid_reg, rsp_valid_next;
    status_t rsp_status_reg;
    data_t   rsp_value_reg;

    logic             cmd_ready;
    logic             cmd_xfer;
    logic             exec_done;
    logic [31:0]      sel_wide;
    logic             sel_ok;
    logic [SEL_W-1:0] sel_idx;
    logic [PTR_W-1:0] top_sel;
    logic [PTR_W-1:0] tgt_ptr;
    logic             tgt_ok;
    status_t          tgt_status;

    logic              link_we;
    logic [PTR_W-1:0]  link_wdata;
    logic [PTR_W-1:0]  link_rdata;
    logic              data_we;
    data_t             data_rdata;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_xfer)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (exec_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State outputs.
    always_comb
    begin
        cmd_ready = 1'b0;
        exec_done = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd_ready = 1'b1;
            end
            ST_EXEC:
            begin
                exec_done = !rsp_valid_reg || rsp.ready;
            end
            default:
            begin
                cmd_ready = 1'b0;
            end
        endcase
    end

    assign cmd.ready = cmd_ready;
    assign cmd_xfer  = cmd.valid && cmd_ready;

    // Request decode from the registered stack state.
    always_comb
    begin
        sel_wide = 32'(cmd.stack_sel);
        sel_ok   = sel_wide < 32'(STACK_COUNT);
        sel_idx  = sel_wide[SEL_W-1:0];
        top_sel  = sel_ok ? stack_top_reg[sel_idx] : PTR_NULL;
        tgt_ptr  = (cmd.command == CMD_PUSH) ? free_head_reg : top_sel;
        tgt_ok   = sel_ok && (tgt_ptr < PTR_NULL);
        if (tgt_ok)
        begin
            tgt_status = STATUS_DONE;
        end
        else if (cmd.command == CMD_PUSH)
        begin
            tgt_status = STATUS_FULL;
        end
        else
        begin
            tgt_status = STATUS_EMPTY;
        end
    end

    mssp_ram #(
        .WIDTH (PTR_W),
        .DEPTH (POOL_SLOTS)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (op_slot_reg[ADDR_W-1:0]),
        .wdata (link_wdata),
        .re    (cmd_xfer && tgt_ok),
        .raddr (tgt_ptr[ADDR_W-1:0]),
        .rdata (link_rdata)
    );

    mssp_ram #(
        .WIDTH (DATA_W),
        .DEPTH (POOL_SLOTS)
    ) u_data_ram (
        .clk   (clk),
        .we    (data_we),
        .waddr (op_slot_reg[ADDR_W-1:0]),
        .wdata (op_val_reg),
        .re    (cmd_xfer && tgt_ok && (cmd.command == CMD_POP)),
        .raddr (tgt_ptr[ADDR_W-1:0]),
        .rdata (data_rdata)
    );

    // Write-back in ST_EXEC, once the response register is free.
    always_comb
    begin
        link_we        = exec_done && op_ok_reg;
        data_we        = exec_done && op_ok_reg && (op_cmd_reg == CMD_PUSH);
        free_head_next = free_head_reg;
        fill_next      = fill_reg;
        if (op_cmd_reg == CMD_PUSH)
        begin
            link_wdata = stack_top_reg[op_idx_reg];
            // A slot at or past the fill mark was never linked and still chains to
            // the next index, so its stored link is not used.
            if (op_fresh_reg)
            begin
                free_head_next = op_slot_reg + PTR_W'(1);
                fill_next      = fill_reg + PTR_W'(1);
            end
            else
            begin
                free_head_next = link_rdata;
            end
        end
        else
        begin
            link_wdata     = free_head_reg;
            free_head_next = op_slot_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            free_head_reg <= '0;
            fill_reg      <= '0;
            rsp_valid_reg <= 1'b0;
            for (int i = 0; i < STACK_COUNT; i++)
            begin
                stack_top_reg[i] <= PTR_NULL;
            end
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            if (exec_done && op_ok_reg)
            begin
                free_head_reg <= free_head_next;
                fill_reg      <= fill_next;
                if (op_cmd_reg == CMD_PUSH)
                begin
                    stack_top_reg[op_idx_reg] <= op_slot_reg;
                end
                else
                begin
                    stack_top_reg[op_idx_reg] <= link_rdata;
                end
            end
        end
    end

    // Request capture and response payload.
    always_ff @(posedge clk)
    begin
        if (cmd_xfer)
        begin
            op_cmd_reg    <= cmd.command;
            op_idx_reg    <= sel_idx;
            op_val_reg    <= cmd.push_value;
            op_slot_reg   <= tgt_ptr;
            op_ok_reg     <= tgt_ok;
            op_fresh_reg  <= tgt_ptr >= fill_reg;
            op_status_reg <= tgt_status;
        end
        if (exec_done)
        begin
            rsp_status_reg <= op_status_reg;
            if (op_ok_reg && (op_cmd_reg == CMD_POP))
            begin
                rsp_value_reg <= data_rdata;
            end
            else
            begin
                rsp_value_reg <= '0;
            end
        end
    end

    always_comb
    begin
        if (exec_done)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.status    = rsp_status_reg;
    assign rsp.pop_value = rsp_value_reg;
endmodule

FILE: rtl/mssp_ram.sv
// ----------------------------------------------------------------------------
// mssp_ram: simple dual-port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module mssp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

FILE: rtl/mssp_checker.sv
// ----------------------------------------------------------------------------
// mssp_checker: port-level checks for the multi-stack shared pool
// Watches both channels and checks response ordering and encoding.
// ----------------------------------------------------------------------------
module mssp_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          cmd_valid,
    input logic                          cmd_ready,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input mssp_pkg::status_t             rsp_status,
    input logic [mssp_pkg::DATA_W-1:0]   rsp_pop_value
);
    import mssp_pkg::*;

    logic       cmd_xfer;
    logic       rsp_xfer;
    logic [1:0] pending_reg;

    assign cmd_xfer = cmd_valid && cmd_ready;
    assign rsp_xfer = rsp_valid && rsp_ready;

    // Requests accepted whose response has not yet been transferred.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_reg + 2'(cmd_xfer) - 2'(rsp_xfer);
        end
    end

    a_rsp_has_request: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (pending_reg != 2'd0))
        else $error("response shown with no outstanding request");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_xfer |=> !cmd_ready)
        else $error("new request accepted while one is in progress");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> ((rsp_status == STATUS_DONE) || (rsp_status == STATUS_FULL) ||
                       (rsp_status == STATUS_EMPTY)))
        else $error("undefined status code");

    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp_status != STATUS_DONE)) |-> (rsp_pop_value == '0))
        else $error("refused operation returned a nonzero value");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> rsp_valid)
        else $error("response dropped before transfer");
endmodule

bind multi_stack_shared_pool mssp_checker u_mssp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_valid     (cmd.valid),
    .cmd_ready     (cmd.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_status    (rsp.status),
    .rsp_pop_value (rsp.pop_value)
);

FILE: tb/mssp_pool_checker.sv
// ----------------------------------------------------------------------------
// mssp_pool_checker: response checker for the multi-stack shared pool
// Watches both channels. Every command transfer is run through a local
// model of the slot pool to predict its response, and every response
// transfer is compared with the oldest prediction still outstanding.
// ----------------------------------------------------------------------------
module mssp_pool_checker #(
    parameter int POOL_SLOTS  = mssp_pkg::DEF_POOL_SLOTS,
    parameter int STACK_COUNT = mssp_pkg::DEF_STACK_COUNT
) (
    input  logic clk,
    input  logic rst_n,
    mssp_cmd_if  cmd,
    mssp_rsp_if  rsp,
    output int   fail_count,
    output int   pending
);
    import mssp_pkg::*;

    localparam int LINK_W = $clog2(POOL_SLOTS) + 1;

    typedef logic [LINK_W-1:0] link_t;

    // One past the last slot index marks the end of a chain.
    localparam link_t LINK_NULL = link_t'(POOL_SLOTS);

    typedef struct packed {
        status_t status;
        data_t   pop_value;
    } outcome_t;

    data_t    slot_word [POOL_SLOTS];
    link_t    slot_next [POOL_SLOTS];
    link_t    top_of [STACK_COUNT];
    link_t    free_slot;
    outcome_t outcome_q [$];
    outcome_t want;
    int       errors;

    function automatic void empty_pool();
        for (int i = 0; i < POOL_SLOTS; i++)
        begin
            slot_word[i] = '0;
            slot_next[i] = link_t'(i + 1);
        end
        slot_next[POOL_SLOTS-1] = LINK_NULL;
        for (int i = 0; i < STACK_COUNT; i++)
        begin
            top_of[i] = LINK_NULL;
        end
        free_slot = '0;
    endfunction

    function automatic outcome_t apply_op(cmd_t op, sel_t sel, data_t value);
        outcome_t res;
        link_t    slot;
        res.status    = STATUS_DONE;
        res.pop_value = '0;
        if (int'(sel) >= STACK_COUNT)
        begin
            res.status = (op == CMD_POP) ? STATUS_EMPTY : STATUS_FULL;
        end
        else if (op == CMD_PUSH)
        begin
            slot = free_slot;
            if (slot >= POOL_SLOTS)
            begin
                res.status = STATUS_FULL;
            end
            else
            begin
                slot_word[slot] = value;
                free_slot       = slot_next[slot];
                slot_next[slot] = top_of[sel];
                top_of[sel]     = slot;
            end
        end
        else
        begin
            slot = top_of[sel];
            if (slot >= POOL_SLOTS)
            begin
                res.status = STATUS_EMPTY;
            end
            else
            begin
                res.pop_value   = slot_word[slot];
                top_of[sel]     = slot_next[slot];
                slot_next[slot] = free_slot;
                free_slot       = slot;
            end
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            empty_pool();
            outcome_q.delete();
            errors = 0;
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            // The response is checked first; a request accepted at this same
            // edge cannot have produced it yet.
            if (rsp.valid && rsp.ready)
            begin
                if (outcome_q.size() == 0)
                begin
                    $display("%0t: unexpected response: expected none, got status %0d pop_value %0d",
                             $time, rsp.status, $signed(rsp.pop_value));
                    errors++;
                end
                else
                begin
                    want = outcome_q.pop_front();
                    if (rsp.status !== want.status)
                    begin
                        $display("%0t: status mismatch: expected %0d, got %0d",
                                 $time, want.status, rsp.status);
                        errors++;
                    end
                    if (rsp.pop_value !== want.pop_value)
                    begin
                        $display("%0t: pop_value mismatch: expected %0d, got %0d",
                                 $time, $signed(want.pop_value), $signed(rsp.pop_value));
                        errors++;
                    end
                end
            end
            if (cmd.valid && cmd.ready)
            begin
                outcome_q.insert(outcome_q.size(),
                                 apply_op(cmd.command, cmd.stack_sel, cmd.push_value));
            end
            fail_count <= errors;
            pending    <= outcome_q.size();
        end
    end

endmodule

FILE: tb/tb_multi_stack_shared_pool.sv
// ----------------------------------------------------------------------------
// tb_multi_stack_shared_pool: testbench for the multi-stack shared pool
// Drives push and pop requests, first a short directed sequence and then
// random phases, most leaning toward pushes or pops so that the pool fills
// up and every stack drains. Both channels stall at random outside a steady
// stretch; the checker beside the block predicts and compares every response.
// ----------------------------------------------------------------------------
module tb_multi_stack_shared_pool;
    import mssp_pkg::*;

    localparam int IDLE_PCT     = 26;
    localparam int RANDOM_ITEMS = 800;
    localparam int STEADY_FIRST = 250;
    localparam int STEADY_LAST  = 400;
    localparam int DRAIN_CYCLES = 10;
    localparam int STALL_LIMIT  = 5000;

    logic clk;
    logic rst_n;
    logic steady;
    int   fail_count;
    int   pending;
    int   quiet_cycles;

    mssp_cmd_if cmd_ch ();
    mssp_rsp_if rsp_ch ();

    multi_stack_shared_pool #(
        .POOL_SLOTS  (DEF_POOL_SLOTS),
        .STACK_COUNT (DEF_STACK_COUNT)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    mssp_pool_checker #(
        .POOL_SLOTS  (DEF_POOL_SLOTS),
        .STACK_COUNT (DEF_STACK_COUNT)
    ) pool_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd_ch),
        .rsp        (rsp_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        rsp_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Ends the run when no transfer has happened on either channel for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_op(cmd_t op, sel_t sel, data_t value);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid      <= 1'b1;
        cmd_ch.command    <= op;
        cmd_ch.stack_sel  <= sel;
        cmd_ch.push_value <= value;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
    endtask

    initial
    begin
        int    push_pct;
        int    phase_left;
        int    phase_idx;
        cmd_t  op;
        data_t value;

        push_pct   = 50;
        phase_left = 0;
        phase_idx  = 0;

        rst_n             <= 1'b0;
        steady            <= 1'b0;
        cmd_ch.valid      <= 1'b0;
        cmd_ch.command    <= CMD_PUSH;
        cmd_ch.stack_sel  <= '0;
        cmd_ch.push_value <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Pops on empty stacks, with a nonzero value that must be ignored.
        send_op(CMD_POP, 2'd0, 32'hDEAD_BEEF);
        send_op(CMD_POP, 2'd1, 32'hFFFF_FFFF);
        send_op(CMD_POP, 2'd2, 32'h8000_0000);
        send_op(CMD_POP, 2'd3, 32'h7FFF_FFFF);

        // Extreme words on every stack, then LIFO order on one of them.
        send_op(CMD_PUSH, 2'd0, 32'h7FFF_FFFF);
        send_op(CMD_PUSH, 2'd1, 32'h8000_0000);
        send_op(CMD_PUSH, 2'd2, 32'h0000_0000);
        send_op(CMD_PUSH, 2'd3, 32'hFFFF_FFFF);
        send_op(CMD_PUSH, 2'd0, 32'h1234_5678);
        send_op(CMD_PUSH, 2'd0, 32'hA5A5_A5A5);
        send_op(CMD_POP,  2'd0, 32'h0000_0000);
        send_op(CMD_POP,  2'd0, 32'h5A5A_5A5A);
        send_op(CMD_POP,  2'd0, 32'h0000_0001);
        send_op(CMD_POP,  2'd0, 32'h0000_0000);
        send_op(CMD_POP,  2'd3, 32'h0000_0000);
        send_op(CMD_POP,  2'd2, 32'hFFFF_FFFF);
        send_op(CMD_POP,  2'd1, 32'h0000_0000);
        send_op(CMD_POP,  2'd1, 32'h0000_0000);

        // Most phases lean toward pushes or pops, so the pool runs full and the
        // stacks run dry many times over.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (phase_left == 0)
            begin
                case (phase_idx % 6)
                    0: push_pct = 92;
                    1: push_pct = 8;
                    2: push_pct = 55;
                    3: push_pct = 96;
                    4: push_pct = 4;
                    default: push_pct = 50;
                endcase
                phase_idx++;
                phase_left = $urandom_range(60, 120);
            end
            phase_left--;
            steady <= (n >= STEADY_FIRST) && (n < STEADY_LAST);
            op = ($urandom_range(0, 99) < push_pct) ? CMD_PUSH : CMD_POP;
            case ($urandom_range(0, 15))
                0: value = 32'h0000_0000;
                1: value = 32'hFFFF_FFFF;
                2: value = 32'h7FFF_FFFF;
                3: value = 32'h8000_0000;
                default: value = $urandom();
            endcase
            send_op(op, sel_t'($urandom_range(0, 3)), value);
        end
        cmd_ch.valid <= 1'b0;
        steady       <= 1'b0;

        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/mssp_pkg.sv
rtl/mssp_cmd_if.sv
rtl/mssp_rsp_if.sv
rtl/mssp_ram.sv
rtl/multi_stack_shared_pool.sv
rtl/mssp_checker.sv
tb/mssp_pool_checker.sv
tb/tb_multi_stack_shared_pool.sv
